// File: hw/rtl/dtc_pkg.sv
// Shared constants and types for the dual thresholded centroid core.
`default_nettype none

package dtc_pkg;

   // Frame geometry and output format.
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int FRAC_BITS  = 8;

   // Counter widths follow from the frame geometry.
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int COORD_W = (COL_W > ROW_W) ? COL_W : ROW_W;

   // Fixed field and accumulator widths.
   localparam int PIX_W     = 8;
   localparam int FW_W      = 11;
   localparam int WSUM_W    = 28;
   localparam int MOM_W     = 38;
   localparam int OUT_W     = 18;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 11;

   // Column wrap compare needs room for column plus one and for the width register.
   localparam int CMP_W = ((COL_W + 1) > FW_W) ? (COL_W + 1) : FW_W;

   // Shared multiplier product width.
   localparam int PROD_W = COORD_W + PIX_W;

   // Divider: numerator is (2 * moment + sum) shifted by the fraction bits.
   localparam int NUM_W  = MOM_W + 2 + FRAC_BITS;
   localparam int DEN_W  = WSUM_W + 1;
   localparam int REM_W  = DEN_W;
   localparam int DCNT_W = $clog2(NUM_W);

   // Register reset values.
   localparam logic [FW_W-1:0]  FRAME_WIDTH_RESET      = FW_W'(640);
   localparam logic [PIX_W-1:0] TARGET_THRESHOLD_RESET = PIX_W'(200);
   localparam logic [PIX_W-1:0] SPOT_THRESHOLD_RESET   = PIX_W'(5);

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH      = 2'd0,
      CSR_TARGET_THRESHOLD = 2'd1,
      CSR_SPOT_THRESHOLD   = 2'd2
   } csr_index_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_DIV_STORE,
      ST_FINISH
   } state_type;

   // Accumulation terms, one per pass through the shared multiply-add.
   typedef enum logic [2:0] {
      TERM_TW,
      TERM_TX,
      TERM_TY,
      TERM_SW,
      TERM_SX,
      TERM_SY
   } term_type;

   // Division jobs at the end of a frame.
   typedef enum logic [1:0] {
      JOB_TX,
      JOB_TY,
      JOB_SX,
      JOB_SY
   } job_type;

endpackage

`default_nettype wire

// File: hw/rtl/dual_thresholded_centroid_core.sv
// Sequence: an ordinary pixel's word is loaded into the output register after 6 multiply-add
// passes, once that register is free. The last pixel of a frame adds four divisions (48 quotient
// bits each on the shared restoring divider) before its word is loaded. A new pixel is taken only
// after the previous pixel's word has been loaded into the output register.
// Reset clears the sequencer, counters, accumulators and output valid, and loads frame
// width 640, target threshold 200 and spot threshold 5; no clearing pass is needed.
`default_nettype none

module dual_thresholded_centroid_core
   import dtc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // Configuration write channel.
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_data,
   // Pixel input channel.
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [PIX_W-1:0]     req_target_pixel,
   input  wire logic [PIX_W-1:0]     req_spot_pixel,
   input  wire logic                 req_last_pixel,
   // Result channel.
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [PIX_W-1:0]          rsp_merged_pixel,
   output logic                      rsp_frame_done,
   output logic [OUT_W-1:0]          rsp_target_x,
   output logic [OUT_W-1:0]          rsp_target_y,
   output logic                      rsp_target_valid,
   output logic [OUT_W-1:0]          rsp_spot_x,
   output logic [OUT_W-1:0]          rsp_spot_y,
   output logic                      rsp_spot_valid
);

   // Sequencer state.
   state_type          state_ff, state_in;
   term_type           term_ff;
   job_type            job_ff;
   logic [DCNT_W-1:0]  dcnt_ff;

   // Configuration registers.
   logic [FW_W-1:0]    frame_width_ff;
   logic [PIX_W-1:0]   target_thr_ff;
   logic [PIX_W-1:0]   spot_thr_ff;

   // Captured input word.
   logic [PIX_W-1:0]   tpix_ff;
   logic [PIX_W-1:0]   spix_ff;
   logic               last_ff;
   logic               thit_ff;
   logic               shit_ff;

   // Frame state.
   logic [COL_W-1:0]   col_ff;
   logic [ROW_W-1:0]   row_ff;
   logic [WSUM_W-1:0]  tw_ff;
   logic [MOM_W-1:0]   tx_ff;
   logic [MOM_W-1:0]   ty_ff;
   logic [WSUM_W-1:0]  sw_ff;
   logic [MOM_W-1:0]   sx_ff;
   logic [MOM_W-1:0]   sy_ff;

   // Divider state.
   logic [NUM_W-1:0]   num_ff;
   logic [DEN_W-1:0]   den_ff;
   logic [REM_W-1:0]   rem_ff;
   logic [OUT_W-1:0]   quo_ff;
   logic               ovf_ff;

   // Per-frame centroid results.
   logic [OUT_W-1:0]   res_tx_ff;
   logic [OUT_W-1:0]   res_ty_ff;
   logic [OUT_W-1:0]   res_sx_ff;
   logic [OUT_W-1:0]   res_sy_ff;
   logic               tvalid_ff;
   logic               svalid_ff;

   // Output register.
   logic               rsp_valid_ff;
   logic [PIX_W-1:0]   rsp_merged_ff;
   logic               rsp_done_ff;
   logic [OUT_W-1:0]   rsp_tx_ff;
   logic [OUT_W-1:0]   rsp_ty_ff;
   logic               rsp_tvalid_ff;
   logic [OUT_W-1:0]   rsp_sx_ff;
   logic [OUT_W-1:0]   rsp_sy_ff;
   logic               rsp_svalid_ff;

   // Control strobes from the output decode.
   logic               accept;
   logic               acc_step;
   logic               last_term;
   logic               div_load;
   logic               div_run;
   logic               div_store;
   logic               div_done;
   logic               load_out;

   // Shared multiply-add datapath.
   logic [COORD_W-1:0] mul_coord;
   logic [PIX_W-1:0]   mul_pix;
   logic [PROD_W-1:0]  prod;
   logic [MOM_W-1:0]   acc_sel;
   logic [MOM_W-1:0]   acc_sum;
   logic               term_hit;

   // Column wrap logic.
   logic [CMP_W-1:0]   fw_ext;
   logic [CMP_W-1:0]   w_eff;
   logic               col_wrap;

   // Divider datapath.
   logic [MOM_W-1:0]   job_mom;
   logic [WSUM_W-1:0]  job_sum;
   logic [REM_W:0]     trial;
   logic [REM_W:0]     diff;
   logic               ge;
   logic [OUT_W-1:0]   job_result;

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            if (term_ff == TERM_SY) state_in = last_ff ? ST_DIV_LOAD : ST_FINISH;
         end
         ST_DIV_LOAD: begin
            state_in = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            if (dcnt_ff == DCNT_W'(NUM_W - 1)) state_in = ST_DIV_STORE;
         end
         ST_DIV_STORE: begin
            state_in = (job_ff == JOB_SY) ? ST_FINISH : ST_DIV_LOAD;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output and strobe decode.
   always_comb begin
      req_ready = 1'b0;
      acc_step  = 1'b0;
      div_load  = 1'b0;
      div_run   = 1'b0;
      div_store = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         ST_IDLE:      req_ready = 1'b1;
         ST_ACCUM:     acc_step  = 1'b1;
         ST_DIV_LOAD:  div_load  = 1'b1;
         ST_DIV_RUN:   div_run   = 1'b1;
         ST_DIV_STORE: div_store = 1'b1;
         ST_FINISH:    load_out  = !rsp_valid_ff || rsp_ready;
         default:      req_ready = 1'b0;
      endcase
   end

   assign accept    = req_valid && req_ready;
   assign last_term = (term_ff == TERM_SY);
   assign div_done  = div_store && (job_ff == JOB_SY);
   assign csr_ready = 1'b1;

   // Operand selection for the shared multiply-add.
   always_comb begin
      case (term_ff)
         TERM_TX, TERM_SX: mul_coord = COORD_W'(col_ff);
         TERM_TY, TERM_SY: mul_coord = COORD_W'(row_ff);
         default:          mul_coord = COORD_W'(1);
      endcase
      case (term_ff)
         TERM_TW, TERM_TX, TERM_TY: begin
            mul_pix  = tpix_ff;
            term_hit = thit_ff;
         end
         default: begin
            mul_pix  = spix_ff;
            term_hit = shit_ff;
         end
      endcase
      case (term_ff)
         TERM_TW: acc_sel = MOM_W'(tw_ff);
         TERM_TX: acc_sel = tx_ff;
         TERM_TY: acc_sel = ty_ff;
         TERM_SW: acc_sel = MOM_W'(sw_ff);
         TERM_SX: acc_sel = sx_ff;
         TERM_SY: acc_sel = sy_ff;
         default: acc_sel = '0;
      endcase
   end

   assign prod    = PROD_W'(mul_coord) * PROD_W'(mul_pix);
   assign acc_sum = acc_sel + MOM_W'(prod);

   // Effective row width, clamped into one to the maximum width.
   always_comb begin
      fw_ext = CMP_W'(frame_width_ff);
      if (fw_ext == '0) begin
         w_eff = CMP_W'(1);
      end else if (fw_ext > CMP_W'(MAX_WIDTH)) begin
         w_eff = CMP_W'(MAX_WIDTH);
      end else begin
         w_eff = fw_ext;
      end
   end

   assign col_wrap = (CMP_W'(col_ff) + CMP_W'(1)) >= w_eff;

   // Division job operand selection.
   always_comb begin
      case (job_ff)
         JOB_TX: begin
            job_mom = tx_ff;
            job_sum = tw_ff;
         end
         JOB_TY: begin
            job_mom = ty_ff;
            job_sum = tw_ff;
         end
         JOB_SX: begin
            job_mom = sx_ff;
            job_sum = sw_ff;
         end
         default: begin
            job_mom = sy_ff;
            job_sum = sw_ff;
         end
      endcase
   end

   // One restoring division step.
   assign trial      = {rem_ff, num_ff[NUM_W-1]};
   assign ge         = trial >= {1'b0, den_ff};
   assign diff       = trial - {1'b0, den_ff};
   assign job_result = ovf_ff ? {OUT_W{1'b1}} : quo_ff;

   // Sequencer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         term_ff  <= TERM_TW;
         job_ff   <= JOB_TX;
         dcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            term_ff <= TERM_TW;
         end else if (acc_step && !last_term) begin
            term_ff <= term_type'(term_ff + 3'd1);
         end
         if (acc_step) begin
            job_ff <= JOB_TX;
         end else if (div_store && !div_done) begin
            job_ff <= job_type'(job_ff + 2'd1);
         end
         if (div_load) begin
            dcnt_ff <= '0;
         end else if (div_run) begin
            dcnt_ff <= dcnt_ff + DCNT_W'(1);
         end
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff <= FRAME_WIDTH_RESET;
         target_thr_ff  <= TARGET_THRESHOLD_RESET;
         spot_thr_ff    <= SPOT_THRESHOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:      frame_width_ff <= csr_data[FW_W-1:0];
            CSR_TARGET_THRESHOLD: target_thr_ff  <= csr_data[PIX_W-1:0];
            CSR_SPOT_THRESHOLD:   spot_thr_ff    <= csr_data[PIX_W-1:0];
            default:              frame_width_ff <= frame_width_ff;
         endcase
      end
   end

   // Capture the input word and its threshold decisions.
   always_ff @(posedge clock) begin
      if (accept) begin
         tpix_ff <= req_target_pixel;
         spix_ff <= req_spot_pixel;
         last_ff <= req_last_pixel;
         thit_ff <= req_target_pixel > target_thr_ff;
         shit_ff <= req_spot_pixel > spot_thr_ff;
      end
   end

   // Accumulators and position counters; the frame clears after the last division.
   always_ff @(posedge clock) begin
      if (reset || div_done) begin
         col_ff <= '0;
         row_ff <= '0;
         tw_ff  <= '0;
         tx_ff  <= '0;
         ty_ff  <= '0;
         sw_ff  <= '0;
         sx_ff  <= '0;
         sy_ff  <= '0;
      end else if (acc_step) begin
         if (term_hit) begin
            case (term_ff)
               TERM_TW: tw_ff <= acc_sum[WSUM_W-1:0];
               TERM_TX: tx_ff <= acc_sum;
               TERM_TY: ty_ff <= acc_sum;
               TERM_SW: sw_ff <= acc_sum[WSUM_W-1:0];
               TERM_SX: sx_ff <= acc_sum;
               TERM_SY: sy_ff <= acc_sum;
               default: tw_ff <= tw_ff;
            endcase
         end
         if (last_term) begin
            if (col_wrap) begin
               col_ff <= '0;
               if (row_ff < ROW_W'(MAX_HEIGHT - 1)) row_ff <= row_ff + ROW_W'(1);
            end else begin
               col_ff <= col_ff + COL_W'(1);
            end
         end
      end
   end

   // Shared divider; a zero sum leaves the quotient at zero.
   always_ff @(posedge clock) begin
      if (div_load) begin
         num_ff <= (NUM_W'({job_mom, 1'b0}) + NUM_W'(job_sum)) << FRAC_BITS;
         den_ff <= {job_sum, 1'b0};
         rem_ff <= '0;
         quo_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (div_run && (job_sum != '0)) begin
         num_ff <= num_ff << 1;
         rem_ff <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
         quo_ff <= {quo_ff[OUT_W-2:0], ge};
         ovf_ff <= ovf_ff | quo_ff[OUT_W-1];
      end
   end

   // Store each centroid as its division completes.
   always_ff @(posedge clock) begin
      if (div_store) begin
         case (job_ff)
            JOB_TX: begin
               res_tx_ff <= job_result;
               tvalid_ff <= tw_ff != '0;
            end
            JOB_TY: res_ty_ff <= job_result;
            JOB_SX: begin
               res_sx_ff <= job_result;
               svalid_ff <= sw_ff != '0;
            end
            default: res_sy_ff <= job_result;
         endcase
      end
   end

   // Output register valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Output register payload; centroid fields show only on the last pixel.
   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_merged_ff <= shit_ff ? spix_ff : tpix_ff;
         rsp_done_ff   <= last_ff;
         rsp_tx_ff     <= last_ff ? res_tx_ff : '0;
         rsp_ty_ff     <= last_ff ? res_ty_ff : '0;
         rsp_tvalid_ff <= last_ff && tvalid_ff;
         rsp_sx_ff     <= last_ff ? res_sx_ff : '0;
         rsp_sy_ff     <= last_ff ? res_sy_ff : '0;
         rsp_svalid_ff <= last_ff && svalid_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_merged_pixel = rsp_merged_ff;
   assign rsp_frame_done   = rsp_done_ff;
   assign rsp_target_x     = rsp_tx_ff;
   assign rsp_target_y     = rsp_ty_ff;
   assign rsp_target_valid = rsp_tvalid_ff;
   assign rsp_spot_x       = rsp_sx_ff;
   assign rsp_spot_y       = rsp_sy_ff;
   assign rsp_spot_valid   = rsp_svalid_ff;

endmodule

`default_nettype wire

// File: hw/rtl/dtc_checker.sv
// Port-level assertions for the dual thresholded centroid core, with their bind.
`default_nettype none

module dtc_checker
   import dtc_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic [PIX_W-1:0]     req_target_pixel,
   input wire logic [PIX_W-1:0]     req_spot_pixel,
   input wire logic                 req_last_pixel,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [PIX_W-1:0]     rsp_merged_pixel,
   input wire logic                 rsp_frame_done,
   input wire logic [OUT_W-1:0]     rsp_target_x,
   input wire logic [OUT_W-1:0]     rsp_target_y,
   input wire logic                 rsp_target_valid,
   input wire logic [OUT_W-1:0]     rsp_spot_x,
   input wire logic [OUT_W-1:0]     rsp_spot_y,
   input wire logic                 rsp_spot_valid
);

   // The core works on one pixel at a time, so it is busy right after taking one.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input ready stayed high after an accepted word");

   // A waiting input word holds until it is taken.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_ready) |=> (req_valid && $stable(req_target_pixel)
         && $stable(req_spot_pixel) && $stable(req_last_pixel)))
      else $error("waiting input word changed");

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_merged_pixel)
         && $stable(rsp_frame_done) && $stable(rsp_target_x) && $stable(rsp_spot_x)))
      else $error("stalled result word changed");

   // Valid flags only appear on a frame-done word.
   a_valid_needs_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_frame_done) |-> (!rsp_target_valid && !rsp_spot_valid))
      else $error("centroid valid without frame done");

   // An invalid centroid reads as zero.
   a_zero_when_invalid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_target_valid || (rsp_target_x == '0 && rsp_target_y == '0))
         && (rsp_spot_valid || (rsp_spot_x == '0 && rsp_spot_y == '0))))
      else $error("invalid centroid with nonzero coordinates");

endmodule

bind dual_thresholded_centroid_core dtc_checker u_dtc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_target_pixel (req_target_pixel),
   .req_spot_pixel   (req_spot_pixel),
   .req_last_pixel   (req_last_pixel),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_merged_pixel (rsp_merged_pixel),
   .rsp_frame_done   (rsp_frame_done),
   .rsp_target_x     (rsp_target_x),
   .rsp_target_y     (rsp_target_y),
   .rsp_target_valid (rsp_target_valid),
   .rsp_spot_x       (rsp_spot_x),
   .rsp_spot_y       (rsp_spot_y),
   .rsp_spot_valid   (rsp_spot_valid)
);

`default_nettype wire
